/* rtl/utd_pkg.sv */
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared payload types, queue entry type and byte class constants.
// ----------------------------------------------------------------------------
package utd_pkg;

  localparam int unsigned CpW       = 21;
  localparam int unsigned ByteW     = 8;

  localparam logic [CpW-1:0] ReplResetValue = 21'd111;

  // Byte class boundaries.
  localparam logic [ByteW-1:0] AsciiMax = 8'h7F;
  localparam logic [ByteW-1:0] ContMin  = 8'h80;
  localparam logic [ByteW-1:0] ContMax  = 8'hBF;
  localparam logic [ByteW-1:0] Lead2Min = 8'hC0;
  localparam logic [ByteW-1:0] Lead2Max = 8'hDF;
  localparam logic [ByteW-1:0] Lead3Min = 8'hE0;
  localparam logic [ByteW-1:0] Lead3Max = 8'hEF;
  localparam logic [ByteW-1:0] Lead4Min = 8'hF0;
  localparam logic [ByteW-1:0] Lead4Max = 8'hF7;

  // Continuation counts loaded by the lead bytes.
  localparam logic [1:0] PendNone = 2'd0;
  localparam logic [1:0] PendOne  = 2'd1;
  localparam logic [1:0] PendTwo  = 2'd2;
  localparam logic [1:0] PendThree = 2'd3;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           is_replacement;
    logic           last_of_run;
  } out_item_t;

  // One queue entry describes all results of one byte. When both flags are
  // set, the replacement goes out first and the value second.
  typedef struct packed {
    logic           rep_first;
    logic           has_val;
    logic [CpW-1:0] value;
  } op_t;

endpackage

/* rtl/utd_front.sv */
// ----------------------------------------------------------------------------
// UTF-8 decoder front end
// Accepts bytes, tracks the pending sequence and classifies each byte into
// a queue entry describing the results it causes.
// ----------------------------------------------------------------------------
module utd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  utd_pkg::in_item_t item_i,
  output logic              push_o,
  output utd_pkg::op_t      op_o
);

  logic [1:0]              pend_q, pend_d;
  logic [utd_pkg::CpW-1:0] acc_q, acc_d;
  logic [utd_pkg::ByteW-1:0] b;

  assign b = item_i.in_byte;

  always_comb begin
    pend_d       = pend_q;
    acc_d        = acc_q;
    op_o.rep_first = 1'b0;
    op_o.has_val   = 1'b0;
    op_o.value     = '0;

    if (b inside {[8'h00:utd_pkg::AsciiMax]}) begin
      op_o.rep_first = (pend_q != utd_pkg::PendNone);
      op_o.has_val   = 1'b1;
      op_o.value     = {{(utd_pkg::CpW-utd_pkg::ByteW){1'b0}}, b};
      pend_d         = utd_pkg::PendNone;
    end else if (b inside {[utd_pkg::ContMin:utd_pkg::ContMax]}) begin
      if (pend_q != utd_pkg::PendNone) begin
        acc_d  = {acc_q[utd_pkg::CpW-7:0], b[5:0]};
        pend_d = pend_q - 2'd1;
        if (pend_q == utd_pkg::PendOne) begin
          op_o.has_val = 1'b1;
          op_o.value   = acc_d;
        end
      end else begin
        op_o.rep_first = 1'b1;
      end
    end else if (b inside {[utd_pkg::Lead2Min:utd_pkg::Lead2Max]}) begin
      pend_d = utd_pkg::PendOne;
      acc_d  = {{(utd_pkg::CpW-5){1'b0}}, b[4:0]};
    end else if (b inside {[utd_pkg::Lead3Min:utd_pkg::Lead3Max]}) begin
      pend_d = utd_pkg::PendTwo;
      acc_d  = {{(utd_pkg::CpW-4){1'b0}}, b[3:0]};
    end else if (b inside {[utd_pkg::Lead4Min:utd_pkg::Lead4Max]}) begin
      pend_d = utd_pkg::PendThree;
      acc_d  = {{(utd_pkg::CpW-3){1'b0}}, b[2:0]};
    end else begin
      op_o.rep_first = 1'b1;
      pend_d         = utd_pkg::PendNone;
    end

    // A sequence left open at the end of a string yields one replacement.
    // It can only arise when this byte produced nothing else.
    if (item_i.end_of_string) begin
      if (pend_d != utd_pkg::PendNone) begin
        op_o.rep_first = 1'b1;
      end
      pend_d = utd_pkg::PendNone;
      acc_d  = '0;
    end
  end

  assign push_o = accept_i && (op_o.rep_first || op_o.has_val);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= utd_pkg::PendNone;
      acc_q  <= '0;
    end else if (accept_i) begin
      pend_q <= pend_d;
      acc_q  <= acc_d;
    end
  end

endmodule

/* rtl/utd_fifo.sv */
// ----------------------------------------------------------------------------
// UTF-8 decoder queue
// Small first-in first-out queue of classified entries between front and
// back end.
// ----------------------------------------------------------------------------
module utd_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  utd_pkg::op_t wdata_i,
  input  logic         pop_i,
  output utd_pkg::op_t rdata_o,
  output logic         full_o,
  output logic         empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  utd_pkg::op_t  mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/utd_back.sv */
// ----------------------------------------------------------------------------
// UTF-8 decoder back end
// Expands queue entries into one or two output transactions and holds the
// replacement code register.
// ----------------------------------------------------------------------------
module utd_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [utd_pkg::CpW-1:0] cfg_wdata_i,
  input  utd_pkg::op_t            op_i,
  input  logic                    op_valid_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output utd_pkg::out_item_t      out_item_o
);

  logic [utd_pkg::CpW-1:0] repl_q;
  logic                    second_q;
  logic                    two_res;
  logic                    send_rep;
  logic                    accept;

  assign two_res  = op_i.rep_first && op_i.has_val;
  // Second phase of a two-result entry always sends the value.
  assign send_rep = op_i.rep_first && !second_q;

  assign out_valid_o               = op_valid_i;
  assign out_item_o.code_point     = send_rep ? repl_q : op_i.value;
  assign out_item_o.is_replacement = send_rep;
  assign out_item_o.last_of_run    = !two_res || second_q;

  assign accept = out_valid_o && !out_stall_i;
  assign pop_o  = accept && out_item_o.last_of_run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_q   <= utd_pkg::ReplResetValue;
      second_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        repl_q <= cfg_wdata_i;
      end
      if (accept) begin
        second_q <= !out_item_o.last_of_run;
      end
    end
  end

endmodule

/* rtl/utf8_to_code_point_decoder_unit.sv */
// ----------------------------------------------------------------------------
// UTF-8 to code point decoder
// Decodes a stream of UTF-8 bytes into code points, with a configurable
// replacement code for malformed input.
//
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid_i / in_stall_o  utd_pkg::in_item_t
//   out      output     out_valid_o / out_stall_i utd_pkg::out_item_t
//   cfg      input      cfg_we_i                 cfg_wdata_i (replacement)
//
// One byte is accepted per cycle while the queue has room. A result leaves
// the queue in the cycle after its byte at the earliest; a byte with two
// results needs two output transactions, so the output port sets the sustained rate.
// Reset clears the pending sequence and loads the replacement code with 111.
// The input stalls only when the queue between front and back end is full.
// ----------------------------------------------------------------------------
module utf8_to_code_point_decoder_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [utd_pkg::CpW-1:0] cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  utd_pkg::in_item_t       in_item_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output utd_pkg::out_item_t      out_item_o
);

  logic         in_accept;
  logic         push;
  logic         pop;
  logic         full;
  logic         empty;
  utd_pkg::op_t op_front;
  utd_pkg::op_t op_head;

  // The front end takes every byte while the queue has room. Bytes that
  // only advance the sequence state produce no queue entry.
  assign in_stall_o = full;
  assign in_accept  = in_valid_i && !in_stall_o;

  utd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(in_accept),
    .item_i  (in_item_i),
    .push_o  (push),
    .op_o    (op_front)
  );

  // The queue decouples the classifier from output stalls, so a byte can be
  // taken while an earlier result still waits at the output.
  utd_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(op_front),
    .pop_i  (pop),
    .rdata_o(op_head),
    .full_o (full),
    .empty_o(empty)
  );

  // The back end turns each entry into its output transactions, the
  // replacement first when an ASCII byte cut a sequence short.
  utd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .op_i       (op_head),
    .op_valid_i (!empty),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

/* rtl/utd_checker.sv */
// ----------------------------------------------------------------------------
// UTF-8 decoder checker
// Port level assertions on the output channel, bound to the top level.
// ----------------------------------------------------------------------------
module utd_port_assertions (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input utd_pkg::out_item_t      out_item_o
);

  // A stalled transaction stays offered.
  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  // A decoded character is always the final result of its byte.
  a_value_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.is_replacement |-> out_item_o.last_of_run)
    else $error("decoded value not marked last of run");

  // A replacement that is not last is followed at once by the character.
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_item_o.last_of_run
    |=> out_valid_o && !out_item_o.is_replacement && out_item_o.last_of_run)
    else $error("second result of a pair missing");

  // Only a replacement can open a two-result run.
  a_first_is_rep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last_of_run |-> out_item_o.is_replacement)
    else $error("non-replacement result opened a run");

endmodule

bind utf8_to_code_point_decoder_unit utd_port_assertions u_utd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_o (out_item_o)
);
